FILE: hw/rtl/hmq_pkg.sv
// Shared types and constants of the binary min-heap queue.
package hmq_pkg;

    localparam int OP_W   = 2;
    localparam int NODE_W = 17;
    localparam int KEY_W  = 30;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [KEY_W-1:0]  key;
    } entry_t;

    localparam int ENTRY_W = NODE_W + KEY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_PICK,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

FILE: hw/rtl/hmq_if.sv
// Valid/ready channel interfaces for the request and response beats.
interface hmq_req_if;
    logic                       valid;
    logic                       ready;
    logic [hmq_pkg::OP_W-1:0]   opcode;
    logic [hmq_pkg::NODE_W-1:0] node_id;
    logic [hmq_pkg::KEY_W-1:0]  key;

    modport source (output valid, opcode, node_id, key, input ready);
    modport sink (input valid, opcode, node_id, key, output ready);
endinterface

interface hmq_rsp_if #(
    parameter int CNT_W = 11
);
    logic                       valid;
    logic                       ready;
    logic [hmq_pkg::NODE_W-1:0] min_node;
    logic [hmq_pkg::KEY_W-1:0]  min_key;
    logic [CNT_W-1:0]           entry_count;
    logic                       is_empty;
    logic [hmq_pkg::ST_W-1:0]   status;

    modport source (output valid, min_node, min_key, entry_count, is_empty, status,
                    input ready);
    modport sink (input valid, min_node, min_key, entry_count, is_empty, status,
                  output ready);
endinterface

FILE: hw/rtl/hmq_ram.sv
// Heap entry store: one write port, two registered read ports.
module hmq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  hmq_pkg::entry_t       wdata,
    input  logic [AW-1:0]         raddr_a,
    input  logic [AW-1:0]         raddr_b,
    output hmq_pkg::entry_t       rdata_a,
    output hmq_pkg::entry_t       rdata_b
);

    hmq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hw/rtl/hmq_cmp.sv
// Entry order compare: key first, smaller node id breaks a tie.
module hmq_cmp (
    input  hmq_pkg::entry_t a,
    input  hmq_pkg::entry_t b,
    output logic            a_first
);

    always_comb
    begin
        if (a.key != b.key)
        begin
            a_first = (a.key < b.key);
        end
        else
        begin
            a_first = (a.node_id < b.node_id);
        end
    end

endmodule

FILE: hw/rtl/binary_min_heap_queue_top.sv
// Top level of the binary min-heap priority queue with its sift sequencer.
// Binary min-heap priority queue of (key, node id) entries held in one on-chip memory of
// HEAP_DEPTH entries. Each request beat is an insert, an extract-min or a peek; each one
// produces exactly one response beat carrying the minimum entry after the operation (zero
// when empty), the entry count, an empty flag and a status (insert into a full heap and
// extract from an empty heap are refused and leave the heap untouched). Requests are taken
// one at a time: req.ready is high only while the sequencer is idle, and a response may still
// wait in its output register when the next request is taken. A single compare unit is
// reused at every heap level. Insert sifts up, reading the parent and then comparing and
// writing at each level; extract reads the last entry and then sifts down, each level a
// memory read, a pick of the smaller child and a compare against the moving entry and
// write. For the default depth of 1024 an insert climbs at most 10 levels and an extract
// descends at most 9 levels (at most 1023 entries remain). The root entry is mirrored in
// a register, so the response never needs an extra memory read. No clearing pass is
// needed after reset.
module binary_min_heap_queue_top #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    hmq_req_if.sink   req,
    hmq_rsp_if.source rsp
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(HEAP_DEPTH);
    localparam logic [CW-1:0] ONE_POS  = CW'(1);

    // Sequencer state
    hmq_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    pos_reg, pos_next;      // 1-based position of the hole
    hmq_pkg::entry_t  ent_reg, ent_next;      // entry being sifted
    hmq_pkg::entry_t  kid_reg, kid_next;      // smaller child picked this level
    logic [CW-1:0]    kidpos_reg, kidpos_next;
    logic             rvalid_reg, rvalid_next;
    hmq_pkg::status_t status_reg, status_next;
    hmq_pkg::entry_t  root_reg, root_next;

    // Response output register
    logic                       out_valid_reg, out_valid_next;
    logic [hmq_pkg::NODE_W-1:0] min_node_reg, min_node_next;
    logic [hmq_pkg::KEY_W-1:0]  min_key_reg, min_key_next;
    logic [CW-1:0]              out_count_reg, out_count_next;
    logic                       empty_reg, empty_next;
    hmq_pkg::status_t           out_status_reg, out_status_next;

    // Memory and compare unit hookup
    logic            we;
    logic [CW-1:0]   wpos;
    logic [CW-1:0]   wpos_m1;
    hmq_pkg::entry_t wdata;
    logic [AW-1:0]   raddr_a, raddr_b;
    hmq_pkg::entry_t rdata_a, rdata_b;
    hmq_pkg::entry_t cmp_a, cmp_b;
    logic            a_first;

    // Position arithmetic
    logic [CW-1:0] parent_pos;
    logic [CW-1:0] parent_m1;
    logic [CW-1:0] count_m1;
    logic [CW:0]   left_pos;
    logic [CW:0]   right_pos;
    logic [CW:0]   left_m1;
    logic [CW:0]   count_ext;

    assign parent_pos = pos_reg >> 1;
    assign parent_m1  = parent_pos - ONE_POS;
    assign count_m1   = count_reg - ONE_POS;
    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = {pos_reg, 1'b1};
    assign left_m1    = left_pos - {{CW{1'b0}}, 1'b1};
    assign count_ext  = {1'b0, count_reg};
    assign wpos_m1    = wpos - ONE_POS;

    hmq_ram #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (wpos_m1[AW-1:0]),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    hmq_cmp u_cmp (
        .a       (cmp_a),
        .b       (cmp_b),
        .a_first (a_first)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hmq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        ent_reg        <= ent_next;
        kid_reg        <= kid_next;
        kidpos_reg     <= kidpos_next;
        rvalid_reg     <= rvalid_next;
        status_reg     <= status_next;
        root_reg       <= root_next;
        min_node_reg   <= min_node_next;
        min_key_reg    <= min_key_next;
        out_count_reg  <= out_count_next;
        empty_reg      <= empty_next;
        out_status_reg <= out_status_next;
    end

    // Keep the root mirror in step with every write to position one
    always_comb
    begin
        root_next = root_reg;
        if (we && (wpos == ONE_POS))
        begin
            root_next = wdata;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        ent_next        = ent_reg;
        kid_next        = kid_reg;
        kidpos_next     = kidpos_reg;
        rvalid_next     = rvalid_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        min_node_next   = min_node_reg;
        min_key_next    = min_key_reg;
        out_count_next  = out_count_reg;
        empty_next      = empty_reg;
        out_status_next = out_status_reg;

        we      = 1'b0;
        wpos    = pos_reg;
        wdata   = ent_reg;
        raddr_a = parent_m1[AW-1:0];
        raddr_b = left_pos[AW-1:0];
        cmp_a   = kid_reg;
        cmp_b   = ent_reg;
        req.ready = 1'b0;

        // Drop the response once the sink takes the beat
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            hmq_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    status_next = hmq_pkg::ST_OK;
                    case (hmq_pkg::op_t'(req.opcode))
                        hmq_pkg::OP_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = hmq_pkg::ST_FULL;
                                state_next  = hmq_pkg::S_DONE;
                            end
                            else
                            begin
                                count_next       = count_reg + ONE_POS;
                                pos_next         = count_reg + ONE_POS;
                                ent_next.node_id = req.node_id;
                                ent_next.key     = req.key;
                                state_next       = hmq_pkg::S_UP_RD;
                            end
                        end
                        hmq_pkg::OP_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = hmq_pkg::ST_EMPTY;
                                state_next  = hmq_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = hmq_pkg::S_DN_LAST;
                            end
                        end
                        default:
                        begin
                            state_next = hmq_pkg::S_DONE;
                        end
                    endcase
                end
            end

            hmq_pkg::S_UP_RD:
            begin
                // At the root, park the entry; otherwise fetch the parent
                if (pos_reg == ONE_POS)
                begin
                    we         = 1'b1;
                    state_next = hmq_pkg::S_DONE;
                end
                else
                begin
                    raddr_a    = parent_m1[AW-1:0];
                    state_next = hmq_pkg::S_UP_CMP;
                end
            end

            hmq_pkg::S_UP_CMP:
            begin
                cmp_a = ent_reg;
                cmp_b = rdata_a;
                we    = 1'b1;
                if (a_first)
                begin
                    // Move the parent down into the hole and climb
                    wdata      = rdata_a;
                    pos_next   = parent_pos;
                    state_next = hmq_pkg::S_UP_RD;
                end
                else
                begin
                    state_next = hmq_pkg::S_DONE;
                end
            end

            hmq_pkg::S_DN_LAST:
            begin
                raddr_a    = count_m1[AW-1:0];
                state_next = hmq_pkg::S_DN_LOAD;
            end

            hmq_pkg::S_DN_LOAD:
            begin
                ent_next   = rdata_a;
                count_next = count_m1;
                pos_next   = ONE_POS;
                if (count_reg == ONE_POS)
                begin
                    state_next = hmq_pkg::S_DONE;
                end
                else
                begin
                    state_next = hmq_pkg::S_DN_RD;
                end
            end

            hmq_pkg::S_DN_RD:
            begin
                if (left_pos > count_ext)
                begin
                    we         = 1'b1;
                    state_next = hmq_pkg::S_DONE;
                end
                else
                begin
                    raddr_a     = left_m1[AW-1:0];
                    raddr_b     = left_pos[AW-1:0];
                    rvalid_next = (right_pos <= count_ext);
                    state_next  = hmq_pkg::S_DN_PICK;
                end
            end

            hmq_pkg::S_DN_PICK:
            begin
                cmp_a = rdata_b;
                cmp_b = rdata_a;
                if (rvalid_reg && a_first)
                begin
                    kid_next    = rdata_b;
                    kidpos_next = right_pos[CW-1:0];
                end
                else
                begin
                    kid_next    = rdata_a;
                    kidpos_next = left_pos[CW-1:0];
                end
                state_next = hmq_pkg::S_DN_CMP;
            end

            hmq_pkg::S_DN_CMP:
            begin
                cmp_a = kid_reg;
                cmp_b = ent_reg;
                we    = 1'b1;
                if (a_first)
                begin
                    // Pull the smaller child up and descend
                    wdata      = kid_reg;
                    pos_next   = kidpos_reg;
                    state_next = hmq_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = hmq_pkg::S_DONE;
                end
            end

            hmq_pkg::S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = count_reg;
                    empty_next      = (count_reg == '0);
                    out_status_next = status_reg;
                    if (count_reg == '0)
                    begin
                        min_node_next = '0;
                        min_key_next  = '0;
                    end
                    else
                    begin
                        min_node_next = root_reg.node_id;
                        min_key_next  = root_reg.key;
                    end
                    state_next = hmq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = hmq_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.min_node    = min_node_reg;
    assign rsp.min_key     = min_key_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.status      = out_status_reg;

endmodule

FILE: test/binary_min_heap_queue_checker.sv
// Watches the request and response channels of the min-heap queue and scores every response.
module binary_min_heap_queue_checker #(
    parameter int HEAP_DEPTH = 1024,
    parameter int CNT_W      = 11
) (
    input  logic clk,
    input  logic rst_n,
    hmq_req_if   req,
    hmq_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [hmq_pkg::NODE_W-1:0] min_node;
        logic [hmq_pkg::KEY_W-1:0]  min_key;
        logic [CNT_W-1:0]           entry_count;
        logic                       is_empty;
        hmq_pkg::status_t           status;
    } min_report_t;

    hmq_pkg::entry_t heap_mem [1:HEAP_DEPTH];
    int unsigned     heap_fill = 0;
    min_report_t     min_report_q [$];
    int              error_total = 0;

    // Key first, then the smaller node id breaks a tie.
    function automatic bit ranks_ahead(hmq_pkg::entry_t a, hmq_pkg::entry_t b);
        if (a.key != b.key)
            return a.key < b.key;
        return a.node_id < b.node_id;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        hmq_pkg::entry_t held;
        held        = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = held;
    endfunction

    function automatic void bubble_up(int unsigned pos);
        while (pos > 1 && ranks_ahead(heap_mem[pos], heap_mem[pos / 2]))
        begin
            swap_slots(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    function automatic void settle_down(int unsigned pos);
        int unsigned best;
        int unsigned lchild;
        int unsigned rchild;
        bit          moving;
        moving = 1'b1;
        while (moving)
        begin
            best   = pos;
            lchild = pos * 2;
            rchild = lchild + 1;
            if (lchild <= heap_fill && ranks_ahead(heap_mem[lchild], heap_mem[best]))
                best = lchild;
            if (rchild <= heap_fill && ranks_ahead(heap_mem[rchild], heap_mem[best]))
                best = rchild;
            if (best == pos)
                moving = 1'b0;
            else
            begin
                swap_slots(best, pos);
                pos = best;
            end
        end
    endfunction

    // Apply one request to the shadow heap and return the report it should produce.
    function automatic min_report_t heap_apply(logic [hmq_pkg::OP_W-1:0] opcode,
                                               logic [hmq_pkg::NODE_W-1:0] node_id,
                                               logic [hmq_pkg::KEY_W-1:0] key);
        min_report_t r;
        r.status = hmq_pkg::ST_OK;
        case (opcode)
            hmq_pkg::OP_INSERT:
                if (heap_fill >= HEAP_DEPTH)
                    r.status = hmq_pkg::ST_FULL;
                else
                begin
                    heap_fill++;
                    heap_mem[heap_fill].node_id = node_id;
                    heap_mem[heap_fill].key     = key;
                    bubble_up(heap_fill);
                end
            hmq_pkg::OP_EXTRACT:
                if (heap_fill == 0)
                    r.status = hmq_pkg::ST_EMPTY;
                else
                begin
                    heap_mem[1] = heap_mem[heap_fill];
                    heap_fill--;
                    settle_down(1);
                end
            default: ;
        endcase
        if (heap_fill == 0)
        begin
            r.min_node = '0;
            r.min_key  = '0;
        end
        else
        begin
            r.min_node = heap_mem[1].node_id;
            r.min_key  = heap_mem[1].key;
        end
        r.entry_count = CNT_W'(heap_fill);
        r.is_empty    = (heap_fill == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        min_report_t want;
        if (!rst_n)
        begin
            heap_fill = 0;
            min_report_q.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                min_report_q = {min_report_q, heap_apply(req.opcode, req.node_id, req.key)};
            if (rsp.valid && rsp.ready)
            begin
                if (min_report_q.size() == 0)
                begin
                    $error("response beat with no request waiting");
                    error_total++;
                end
                else
                begin
                    want = min_report_q.pop_front();
                    if (rsp.min_node !== want.min_node)
                    begin
                        $error("min_node: expected %0d, got %0d", want.min_node, rsp.min_node);
                        error_total++;
                    end
                    if (rsp.min_key !== want.min_key)
                    begin
                        $error("min_key: expected %0d, got %0d", want.min_key, rsp.min_key);
                        error_total++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, rsp.entry_count);
                        error_total++;
                    end
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
                        error_total++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        error_total++;
                    end
                end
            end
        end
        mismatches  <= error_total;
        outstanding <= min_report_q.size();
    end

endmodule

FILE: test/binary_min_heap_queue_top_test.sv
// Stimulus and verdict for the binary min-heap priority queue.
module binary_min_heap_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = 1024;
    localparam int CNT_W      = 11;
    localparam int NODE_MAX   = (1 << hmq_pkg::NODE_W) - 1;
    localparam int KEY_MAX    = (1 << hmq_pkg::KEY_W) - 1;
    // Spare opcode: the block must treat it as a peek.
    localparam logic [hmq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    // Idle odds per hundred, on both sides.
    localparam int IDLE_PCT = 38;
    // Settle time after the last response before the verdict.
    localparam int DRAIN_CYCLES = 48;

    logic clk;
    logic rst_n;
    // High while neither side idles.
    bit   steady = 1'b0;
    // Number of entries the heap holds, tracked here only to steer the stimulus.
    int   fill_level = 0;
    int   mismatches;
    int   outstanding;

    hmq_req_if                   req_ch ();
    hmq_rsp_if #(.CNT_W(CNT_W))  rsp_ch ();

    binary_min_heap_queue_top #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    binary_min_heap_queue_checker #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .CNT_W      (CNT_W)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Response side: stall at random on each falling edge, never during the steady stretch.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Keys: a narrow band forces ties on key so the node id must decide, extremes hit the
    // ends of the compare, and the rest spread over the whole range.
    function automatic logic [hmq_pkg::KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return hmq_pkg::KEY_W'($urandom_range(7));
        if (roll < 36)
            return hmq_pkg::KEY_W'(KEY_MAX);
        if (roll < 40)
            return '0;
        return hmq_pkg::KEY_W'($urandom);
    endfunction

    function automatic logic [hmq_pkg::NODE_W-1:0] pick_node();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return hmq_pkg::NODE_W'($urandom_range(3));
        if (roll < 26)
            return hmq_pkg::NODE_W'(NODE_MAX);
        return hmq_pkg::NODE_W'($urandom);
    endfunction

    // Drive one request beat and hold it until the block takes it.
    // Enter and leave on a falling edge; valid stays high into the next call.
    task automatic push_req(logic [hmq_pkg::OP_W-1:0] opcode,
                            logic [hmq_pkg::NODE_W-1:0] node_id,
                            logic [hmq_pkg::KEY_W-1:0] key);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.opcode  = opcode;
        req_ch.node_id = node_id;
        req_ch.key     = key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (opcode == hmq_pkg::OP_INSERT && fill_level < HEAP_DEPTH)
            fill_level++;
        else if (opcode == hmq_pkg::OP_EXTRACT && fill_level > 0)
            fill_level--;
        @(negedge clk);
    endtask

    // Random mix of operations; insert and extract odds in percent, the rest are peeks
    // with an occasional spare opcode. Fields are always random, even where ignored.
    task automatic mixed_ops(int count, int ins_pct, int ext_pct);
        int unsigned roll;
        logic [hmq_pkg::OP_W-1:0] opcode;
        repeat (count)
        begin
            roll = $urandom_range(99);
            if (roll < ins_pct)
                opcode = hmq_pkg::OP_INSERT;
            else if (roll < ins_pct + ext_pct)
                opcode = hmq_pkg::OP_EXTRACT;
            else if (roll % 4 == 0)
                opcode = OP_UNUSED;
            else
                opcode = hmq_pkg::OP_PEEK;
            push_req(opcode, pick_node(), pick_key());
        end
    endtask

    // Stimulus.
    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = hmq_pkg::OP_PEEK;
        req_ch.node_id = '0;
        req_ch.key     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-heap refusals and peeks, both opcodes that only look.
        push_req(hmq_pkg::OP_EXTRACT, hmq_pkg::NODE_W'(NODE_MAX), hmq_pkg::KEY_W'(KEY_MAX));
        push_req(hmq_pkg::OP_PEEK, pick_node(), pick_key());
        push_req(OP_UNUSED, pick_node(), pick_key());
        // Field extremes, alternating bit patterns and ties on equal keys.
        push_req(hmq_pkg::OP_INSERT, hmq_pkg::NODE_W'(NODE_MAX), hmq_pkg::KEY_W'(KEY_MAX));
        push_req(hmq_pkg::OP_INSERT, '0, hmq_pkg::KEY_W'(KEY_MAX));
        push_req(hmq_pkg::OP_INSERT, hmq_pkg::NODE_W'(17'h15555),
                 hmq_pkg::KEY_W'(30'h15555555));
        push_req(hmq_pkg::OP_INSERT, hmq_pkg::NODE_W'(17'h0AAAA),
                 hmq_pkg::KEY_W'(30'h2AAAAAAA));
        push_req(hmq_pkg::OP_INSERT, hmq_pkg::NODE_W'(3), '0);
        push_req(hmq_pkg::OP_INSERT, hmq_pkg::NODE_W'(1), '0);
        push_req(hmq_pkg::OP_INSERT, '0, hmq_pkg::KEY_W'(1));
        push_req(hmq_pkg::OP_PEEK, pick_node(), pick_key());
        push_req(OP_UNUSED, hmq_pkg::NODE_W'(NODE_MAX), '0);
        // Drain to empty, then one refused extract more.
        repeat (7)
            push_req(hmq_pkg::OP_EXTRACT, pick_node(), pick_key());
        push_req(hmq_pkg::OP_EXTRACT, pick_node(), pick_key());
        push_req(hmq_pkg::OP_INSERT, pick_node(), pick_key());
        push_req(hmq_pkg::OP_EXTRACT, pick_node(), pick_key());
        push_req(hmq_pkg::OP_PEEK, pick_node(), pick_key());

        // Balanced random traffic, then a stretch with no idling on either side.
        mixed_ops(120, 45, 35);
        steady = 1'b1;
        mixed_ops(80, 50, 30);
        steady = 1'b0;

        // Fill to the brim, then knock on the full heap a few times.
        while (fill_level < HEAP_DEPTH)
            mixed_ops(1, 95, 0);
        repeat (8)
        begin
            push_req(hmq_pkg::OP_INSERT, pick_node(), pick_key());
            mixed_ops(1, 0, 0);
        end

        // Drain-heavy traffic back down from full.
        mixed_ops(350, 25, 65);

        // Stimulus done: drop valid and let every response come home.
        req_ch.valid = 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("binary_min_heap_queue_top_test: clean");
        else
            $display("binary_min_heap_queue_top_test: errors");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("binary_min_heap_queue_top_test: errors");
        $finish;
    end

endmodule
